/* rtl/core/ntn_pkg.sv */
// ntn_pkg: shared constants, types and the accent fold table of the name normalizer
// depends on nothing; used by name_text_normalizer
package ntn_pkg;

    // result queue depth, power of two, at least 4
    localparam int FifoDepthDefault = 4;

    // largest number of results one transaction can produce
    localparam int MaxResults = 3;

    // byte codes
    localparam logic [7:0] ByteLeadC3 = 8'hC3;
    localparam logic [7:0] ByteLeadC5 = 8'hC5;
    localparam logic [7:0] ByteOeUpper = 8'h92;
    localparam logic [7:0] ByteOeLower = 8'h93;
    localparam logic [7:0] ByteSpace = 8'h20;
    localparam logic [7:0] ByteDash = 8'h2D;
    localparam logic [7:0] ByteApos = 8'h27;
    localparam logic [7:0] ByteParenOpen = 8'h28;
    localparam logic [7:0] ByteParenClose = 8'h29;
    localparam logic [7:0] ByteDot = 8'h2E;
    localparam logic [7:0] ByteUpperA = 8'h41;
    localparam logic [7:0] ByteUpperZ = 8'h5A;
    localparam logic [7:0] ByteLowerO = 8'h6F;
    localparam logic [7:0] ByteLowerE = 8'h65;
    localparam logic [7:0] CaseOffset = 8'h20;

    // held lead byte
    typedef enum logic [2:0] {
        LeadNone = 3'b001,
        LeadC3   = 3'b010,
        LeadC5   = 3'b100
    } t_lead;

    // one queued result
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } t_result;

    // plain letter for a trail byte after 0xC3, zero where no fold exists
    function automatic logic [7:0] fold_c3(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0, 5'd2, 5'd4:                 r = 8'h61; // a
            5'd7:                             r = 8'h63; // c
            5'd8, 5'd9, 5'd10, 5'd11:         r = 8'h65; // e
            5'd14, 5'd15:                     r = 8'h69; // i
            5'd20, 5'd22:                     r = 8'h6F; // o
            5'd25, 5'd27, 5'd28:              r = 8'h75; // u
            default:                          r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/name_text_normalizer.sv */
// name_text_normalizer: byte stream name cleanup with a small result queue
// depends on ntn_pkg
// results of an accepted byte are written into the queue and offered behind any results already queued
// throughput: one byte per cycle while each byte gives at most one result and the output takes each result
//   as offered; a byte giving two or three results holds the input back until the queue has three free slots again
// reset: i_rst_n synchronous active low clears lead, space and text flags and empties the queue
module name_text_normalizer #(
    parameter int P_FIFO_DEPTH = ntn_pkg::FifoDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_out_last
);

    localparam int PtrW = $clog2(P_FIFO_DEPTH);
    localparam int CntW = $clog2(P_FIFO_DEPTH + 1);

    // stream state
    ntn_pkg::t_lead r_lead, n_lead;
    logic           r_owed, n_owed;
    logic           r_seen, n_seen;

    // result queue
    ntn_pkg::t_result r_mem [P_FIFO_DEPTH];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [CntW-1:0]  r_count;

    // per-transaction results
    logic [7:0]       txt [2];
    logic [1:0]       k, k_lead;
    logic             fresh, seen_mid, seen_end, fresh_space, sp, in_fire, out_fire;
    logic [1:0]       m;
    logic [7:0]       fold;
    ntn_pkg::t_result e [ntn_pkg::MaxResults];

    assign in_fire  = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;
    assign fold     = ntn_pkg::fold_c3(i_in_byte[4:0]);

    // text bytes produced by this byte
    always_comb begin
        txt[0]      = '0;
        txt[1]      = '0;
        k           = 2'd0;
        fresh       = 1'b1;
        fresh_space = 1'b0;
        n_lead      = ntn_pkg::LeadNone;
        // resolve a held lead
        case (r_lead)
            ntn_pkg::LeadC3: begin
                k = 2'd1;
                if (i_in_byte[7:6] == 2'b10 && fold != 8'h00) begin
                    txt[0] = fold;
                    fresh  = 1'b0;
                end else begin
                    txt[0] = ntn_pkg::ByteLeadC3;
                end
            end
            ntn_pkg::LeadC5: begin
                if (i_in_byte == ntn_pkg::ByteOeUpper || i_in_byte == ntn_pkg::ByteOeLower) begin
                    txt[0] = ntn_pkg::ByteLowerO;
                    txt[1] = ntn_pkg::ByteLowerE;
                    k      = 2'd2;
                    fresh  = 1'b0;
                end else begin
                    txt[0] = ntn_pkg::ByteLeadC5;
                    k      = 2'd1;
                end
            end
            default: ;
        endcase
        k_lead   = k;
        seen_mid = r_seen || (k_lead != 2'd0);
        // the byte on its own
        if (fresh) begin
            if (i_in_byte == ntn_pkg::ByteLeadC3) begin
                n_lead = ntn_pkg::LeadC3;
            end else if (i_in_byte == ntn_pkg::ByteLeadC5) begin
                n_lead = ntn_pkg::LeadC5;
            end else if (i_in_byte inside {[ntn_pkg::ByteUpperA:ntn_pkg::ByteUpperZ]}) begin
                txt[k[0]] = i_in_byte + ntn_pkg::CaseOffset;
                k         = k + 2'd1;
            end else if (i_in_byte inside {ntn_pkg::ByteSpace, ntn_pkg::ByteDash,
                                           ntn_pkg::ByteApos}) begin
                fresh_space = 1'b1;
            end else if (i_in_byte inside {ntn_pkg::ByteParenOpen, ntn_pkg::ByteParenClose,
                                           ntn_pkg::ByteDot}) begin
                // deleted
            end else begin
                txt[k[0]] = i_in_byte;
                k         = k + 2'd1;
            end
        end
        // flush a lead at end of name
        if (i_in_last) begin
            if (n_lead == ntn_pkg::LeadC3) begin
                txt[k[0]] = ntn_pkg::ByteLeadC3;
                k         = k + 2'd1;
            end else if (n_lead == ntn_pkg::LeadC5) begin
                txt[k[0]] = ntn_pkg::ByteLeadC5;
                k         = k + 2'd1;
            end
            n_lead = ntn_pkg::LeadNone;
        end
        seen_end = r_seen || (k != 2'd0);
    end

    // arrange results: owed space, text, end marker
    always_comb begin
        sp = r_owed && (k != 2'd0);
        for (int j = 0; j < ntn_pkg::MaxResults; j++) begin
            e[j] = '{data: 8'h00, has: 1'b1, last: 1'b0};
        end
        if (sp) begin
            e[0].data = ntn_pkg::ByteSpace;
            e[1].data = txt[0];
            e[2].data = txt[1];
        end else begin
            e[0].data = txt[0];
            e[1].data = txt[1];
        end
        m = k + {1'b0, sp};
        if (i_in_last && seen_end && m == 2'd0) begin
            e[0].has = 1'b0;
            m        = 2'd1;
        end
        if (i_in_last && seen_end) begin
            e[m - 2'd1].last = 1'b1;
        end
    end

    // next flags
    always_comb begin
        if (i_in_last) begin
            n_owed = 1'b0;
            n_seen = 1'b0;
        end else begin
            n_seen = seen_end;
            if (fresh_space && seen_mid) begin
                n_owed = 1'b1;
            end else if (k != 2'd0) begin
                n_owed = 1'b0;
            end else begin
                n_owed = r_owed;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= ntn_pkg::LeadNone;
            r_owed <= 1'b0;
            r_seen <= 1'b0;
        end else if (in_fire) begin
            r_lead <= n_lead;
            r_owed <= n_owed;
            r_seen <= n_seen;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int j = 0; j < ntn_pkg::MaxResults; j++) begin
                if (2'(j) < m) begin
                    r_mem[r_wr + PtrW'(j)] <= e[j];
                end
            end
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (in_fire) begin
                r_wr <= r_wr + PtrW'(m);
            end
            if (out_fire) begin
                r_rd <= r_rd + PtrW'(1);
            end
            r_count <= r_count + (in_fire ? CntW'(m) : CntW'(0)) - CntW'(out_fire);
        end
    end

    assign o_ready    = r_count <= CntW'(P_FIFO_DEPTH - ntn_pkg::MaxResults);
    assign o_valid    = r_count != '0;
    assign o_out_byte = r_mem[r_rd].data;
    assign o_has_byte = r_mem[r_rd].has;
    assign o_out_last = r_mem[r_rd].last;

endmodule

/* rtl/core/ntn_checker.sv */
// ntn_checker: port level checks of the name normalizer, bound to the top level
// depends on name_text_normalizer ports only
module ntn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_has_byte,
    input logic       o_out_last
);

    // a result that stalls stays offered unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_has_byte)
            && $stable(o_out_last))
        else $error("stalled result changed");

    // a bare marker closes the name and carries a zero byte
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_out_last && o_out_byte == 8'h00)
        else $error("bad end marker");

    // no upper case letter and no deleted or separator punctuation reaches the output
    a_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_byte |-> (o_out_byte < 8'h41 || o_out_byte > 8'h5A)
            && o_out_byte != 8'h28 && o_out_byte != 8'h29 && o_out_byte != 8'h2E
            && o_out_byte != 8'h2D && o_out_byte != 8'h27)
        else $error("unnormalized byte on output");

    // a name never ends in a space
    a_no_trail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_last |-> o_out_byte != 8'h20)
        else $error("trailing space");

endmodule

bind name_text_normalizer ntn_checker u_ntn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_byte (o_out_byte),
    .o_has_byte (o_has_byte),
    .o_out_last (o_out_last)
);
